// ----- src/nsm_pkg.sv -----
// Shared types and constants for the NFA set-simulation matcher.
package nsm_pkg;

	localparam int STATE_COUNT_DEF = 32;
	localparam int MAX_EDGES_DEF   = 128;
	localparam int STATE_W         = 5;
	localparam int SYM_W           = 8;
	localparam int CMD_W           = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR  = 3'd0,
		CMD_APPEND = 3'd1,
		CMD_BEGIN  = 3'd2,
		CMD_SYMBOL = 3'd3,
		CMD_FINISH = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SYM,
		ST_EPS,
		ST_DONE
	} state_t;

	typedef enum logic {
		REG_START  = 1'b0,
		REG_ACCEPT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [SYM_W-1:0]   label;
		logic [STATE_W-1:0] dst;
		logic [STATE_W-1:0] src;
	} edge_t;

	typedef struct packed {
		logic init_start;
		logic init_zero;
		logic clr_changed;
		logic apply;
		logic eps;
	} set_ctrl_t;

endpackage

// ----- src/nsm_edge_mem.sv -----
// Transition table memory with one write port and one registered read port.
module nsm_edge_mem #(
	parameter int MAX_EDGES = nsm_pkg::MAX_EDGES_DEF,
	parameter int AW        = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  nsm_pkg::edge_t  wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output nsm_pkg::edge_t  rdata,
	output logic            rvld
);
	import nsm_pkg::*;

	edge_t mem [MAX_EDGES];
	edge_t rdata_s1;
	logic  rvld_s1;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvld_s1 <= 1'b0;
		end else begin
			rvld_s1 <= re;
		end
	end

	assign rdata = rdata_s1;
	assign rvld  = rvld_s1;

endmodule

// ----- src/nsm_set_unit.sv -----
// Working state set and the shared edge evaluator applied one transition per cycle.
module nsm_set_unit #(
	parameter int STATE_COUNT = nsm_pkg::STATE_COUNT_DEF,
	parameter int SW          = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  nsm_pkg::set_ctrl_t             ctrl,
	input  logic [nsm_pkg::STATE_W-1:0]    start_index,
	input  logic [nsm_pkg::SYM_W-1:0]      sym,
	input  logic [STATE_COUNT-1:0]         active,
	input  nsm_pkg::edge_t                 edge_in,
	output logic [STATE_COUNT-1:0]         work,
	output logic                           changed
);
	import nsm_pkg::*;

	logic [STATE_COUNT-1:0] work_q;
	logic                   changed_q;
	logic                   ok;
	logic                   start_ok;
	logic [SW-1:0]          src_i;
	logic [SW-1:0]          dst_i;
	logic [SW-1:0]          start_i;
	logic                   hit_sym;
	logic                   hit_eps;

	always_comb begin
		src_i    = SW'(edge_in.src);
		dst_i    = SW'(edge_in.dst);
		start_i  = SW'(start_index);
		ok       = (32'(edge_in.src) < STATE_COUNT) && (32'(edge_in.dst) < STATE_COUNT);
		start_ok = 32'(start_index) < STATE_COUNT;
		hit_sym  = !ctrl.eps && (edge_in.label == sym) && ok && active[src_i];
		hit_eps  = ctrl.eps && (edge_in.label == '0) && ok && work_q[src_i] && !work_q[dst_i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q    <= '0;
			changed_q <= 1'b0;
		end else begin
			if (ctrl.init_start) begin
				work_q <= start_ok ? (STATE_COUNT'(1) << start_i) : '0;
			end else if (ctrl.init_zero) begin
				work_q <= '0;
			end else if (ctrl.apply && (hit_sym || hit_eps)) begin
				work_q[dst_i] <= 1'b1;
			end
			if (ctrl.clr_changed) begin
				changed_q <= 1'b0;
			end else if (ctrl.apply && hit_eps) begin
				changed_q <= 1'b1;
			end
		end
	end

	assign work    = work_q;
	assign changed = changed_q;

endmodule

// ----- src/nfa_set_simulation_matcher.sv -----
// Top level: command sequencer, edge count, active set and result register.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+---------------------------------------
//  s_*      | in  | s_tvalid / s_tready | s_tdata: cmd, edge_source, edge_target, sym
//  m_*      | out | m_tvalid / m_tready | m_tdata: status, accepting, dead
//  cfg_*    | in  | cfg_we              | cfg_index, cfg_data
//
// Clear, append, finish and a symbol on an empty set go straight to the result.
// Begin and symbol walk the edge table once per pass, one edge per cycle through
// the registered read port; a symbol runs one labeled pass, then epsilon passes
// until one adds no state (begin runs only the epsilon passes). Reset clears the
// edge count, active set and registers at once; a result not taken holds the sequencer.
module nfa_set_simulation_matcher #(
	parameter int STATE_COUNT = nsm_pkg::STATE_COUNT_DEF,
	parameter int MAX_EDGES   = nsm_pkg::MAX_EDGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // cmd[2:0], edge_source[7:3], edge_target[12:8], sym[20:13]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // status[0], accepting[1], dead[2]
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);
	import nsm_pkg::*;

	localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int SW = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;

	state_t                 state_q, state_d;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          idx_q, idx_d;
	logic [STATE_COUNT-1:0] active_q;
	logic [STATE_W-1:0]     start_idx_q;
	logic [STATE_W-1:0]     accept_idx_q;
	logic [SYM_W-1:0]       sym_q;
	logic                   status_q;
	logic                   m_tvalid_q;
	logic [2:0]             m_data_q;

	cmd_t                   in_cmd;
	edge_t                  in_edge;
	logic                   in_xfer;
	logic                   full;
	logic                   mem_we;
	logic                   rd_en;
	logic                   pass_done;
	logic                   load_active;
	logic                   load_out;
	set_ctrl_t              ctrl;
	edge_t                  rd_edge;
	logic                   rd_vld;
	logic [STATE_COUNT-1:0] work;
	logic                   changed;
	logic                   acc_now;
	logic                   dead_now;

	assign in_cmd    = cmd_t'(s_tdata[2:0]);
	assign in_edge   = '{label: s_tdata[20:13], dst: s_tdata[12:8], src: s_tdata[7:3]};
	assign in_xfer   = s_tvalid && s_tready;
	assign full      = (count_q == CW'(MAX_EDGES));
	assign mem_we    = in_xfer && (in_cmd == CMD_APPEND) && !full;
	assign rd_en     = ((state_q == ST_SYM) || (state_q == ST_EPS)) && (idx_q < count_q);
	assign pass_done = !rd_en && !rd_vld;

	nsm_edge_mem #(
		.MAX_EDGES(MAX_EDGES),
		.AW       (AW)
	) u_mem (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (mem_we),
		.waddr (count_q[AW-1:0]),
		.wdata (in_edge),
		.re    (rd_en),
		.raddr (idx_q[AW-1:0]),
		.rdata (rd_edge),
		.rvld  (rd_vld)
	);

	nsm_set_unit #(
		.STATE_COUNT(STATE_COUNT),
		.SW         (SW)
	) u_set (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.start_index(start_idx_q),
		.sym        (sym_q),
		.active     (active_q),
		.edge_in    (rd_edge),
		.work       (work),
		.changed    (changed)
	);

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		s_tready    = 1'b0;
		ctrl        = '0;
		load_active = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					idx_d   = '0;
					state_d = ST_DONE;
					case (in_cmd)
						CMD_BEGIN: begin
							ctrl.init_start  = 1'b1;
							ctrl.clr_changed = 1'b1;
							state_d          = ST_EPS;
						end
						CMD_SYMBOL: begin
							if (|active_q) begin
								ctrl.init_zero = 1'b1;
								state_d        = ST_SYM;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_SYM: begin
				ctrl.apply = rd_vld;
				if (rd_en) begin
					idx_d = CW'(idx_q + 1'b1);
				end
				if (pass_done) begin
					idx_d            = '0;
					ctrl.clr_changed = 1'b1;
					state_d          = ST_EPS;
				end
			end
			ST_EPS: begin
				ctrl.eps   = 1'b1;
				ctrl.apply = rd_vld;
				if (rd_en) begin
					idx_d = CW'(idx_q + 1'b1);
				end
				if (pass_done) begin
					if (changed) begin
						idx_d            = '0;
						ctrl.clr_changed = 1'b1;
					end else begin
						load_active = 1'b1;
						state_d     = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			active_q     <= '0;
			start_idx_q  <= '0;
			accept_idx_q <= '0;
			status_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_START:  start_idx_q  <= cfg_data;
					REG_ACCEPT: accept_idx_q <= cfg_data;
					default:    start_idx_q  <= start_idx_q;
				endcase
			end
			if (in_xfer) begin
				status_q <= (in_cmd == CMD_APPEND) && full;
				if (in_cmd == CMD_CLEAR) begin
					count_q <= '0;
				end else if (mem_we) begin
					count_q <= CW'(count_q + 1'b1);
				end
			end
			if (load_active) begin
				active_q <= work;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sym_q <= s_tdata[20:13];
		end
	end

	assign acc_now  = (32'(accept_idx_q) < STATE_COUNT) && active_q[SW'(accept_idx_q)];
	assign dead_now = !(|active_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_data_q   <= '0;
		end else begin
			if (load_out) begin
				m_tvalid_q <= 1'b1;
				m_data_q   <= {dead_now, acc_now, status_q};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, m_data_q};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_EDGES))
		else $error("edge count beyond table depth");

	a_append_grows: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (count_q == CW'($past(count_q) + 1'b1)))
		else $error("append did not advance edge count");

	a_dead_not_acc: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_data_q[2] |-> !m_data_q[1])
		else $error("result both dead and accepting");

	a_read_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld |-> (state_q == ST_SYM || state_q == ST_EPS))
		else $error("table read outside a pass");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q != ST_IDLE))
		else $error("transfer accepted without starting work");

endmodule
